FILE: hw/rtl/http_uri_splitter_defines.svh
// assertion macros shared by the uri splitter rtl
`ifndef HTTP_URI_SPLITTER_DEFINES_SVH
`define HTTP_URI_SPLITTER_DEFINES_SVH

`ifndef ASSERT_OFF

// check on every rising clock edge, reset included
`define HUS_ASSERT(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

// check only while out of reset
`define HUS_ASSERT_RST(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

`else

`define HUS_ASSERT(lbl, clk, prop, msg)
`define HUS_ASSERT_RST(lbl, clk, rst_n, prop, msg)

`endif

`endif

FILE: hw/rtl/hus_pkg.sv
`timescale 1ns / 1ps

package hus_pkg;

  typedef enum logic [3:0] {
    PH_START,
    PH_SLASH,
    PH_PREFIX,
    PH_HOST,
    PH_PORT,
    PH_PATH,
    PH_QUERY,
    PH_FRAG,
    PH_DONE
  } phase_e;

  typedef enum logic [2:0] {
    PART_HOST,
    PART_PORT,
    PART_PATH,
    PART_QUERY,
    PART_FRAG,
    PART_END
  } part_e;

  typedef enum logic [1:0] {
    SCH_NONE,
    SCH_HTTP,
    SCH_HTTPS
  } scheme_e;

  typedef enum logic [1:0] {
    ERR_NONE,
    ERR_SCHEME,
    ERR_HOST,
    ERR_PORT
  } err_e;

  // position inside the scheme prefix, named after what has matched so far
  localparam logic [3:0] PP_NONE     = 4'd0;
  localparam logic [3:0] PP_H        = 4'd1;
  localparam logic [3:0] PP_HT       = 4'd2;
  localparam logic [3:0] PP_HTT      = 4'd3;
  localparam logic [3:0] PP_HTTP     = 4'd4;
  localparam logic [3:0] PP_COLON    = 4'd5;
  localparam logic [3:0] PP_SLASH1   = 4'd6;
  localparam logic [3:0] PP_S        = 4'd7;
  localparam logic [3:0] PP_S_COLON  = 4'd8;
  localparam logic [3:0] PP_S_SLASH1 = 4'd9;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_HASH  = 8'h23;
  localparam logic [7:0] CH_DASH  = 8'h2D;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_QMARK = 8'h3F;
  localparam logic [7:0] CH_UC_A  = 8'h41;
  localparam logic [7:0] CH_UC_Z  = 8'h5A;
  localparam logic [7:0] CH_LC_A  = 8'h61;
  localparam logic [7:0] CH_LC_H  = 8'h68;
  localparam logic [7:0] CH_LC_P  = 8'h70;
  localparam logic [7:0] CH_LC_S  = 8'h73;
  localparam logic [7:0] CH_LC_T  = 8'h74;
  localparam logic [7:0] CH_LC_Z  = 8'h7A;
  localparam logic [7:0] CASE_GAP = 8'h20;

  localparam logic [15:0] PORT_MAX = 16'hFFFF;

  typedef struct packed {
    part_e       part;
    logic [7:0]  ch;
    scheme_e     scheme;
    logic [15:0] port;
    logic        query;
    logic        frag;
    err_e        err;
    logic        last;
  } result_t;

  // next state and optional result of one character after the prefix
  typedef struct packed {
    phase_e      phase;
    logic [15:0] port;
    logic        query;
    logic        frag;
    logic        emit;
    result_t     res;
  } body_t;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= CH_UC_A && c <= CH_UC_Z) ? c + CASE_GAP : c;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == CH_SPACE) || (c >= CH_TAB && c <= CH_CR);
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO && c <= CH_NINE);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    logic [7:0] l;
    l = to_lower(c);
    return is_digit(c) || (l >= CH_LC_A && l <= CH_LC_Z);
  endfunction

endpackage

FILE: hw/rtl/http_uri_splitter.sv
`timescale 1ns / 1ps
`include "http_uri_splitter_defines.svh"

// URI splitter. Takes one character per transaction and gives back tagged
// characters (host lowercased, port, path, query, fragment) plus a closing
// summary or error transaction with last set. A character is registered on
// input and parsed from that register; results go through a four-entry result
// buffer, and a character is parsed only while the buffer has room for two
// results (a lone leading slash yields two), so one character a cycle is
// sustained while that room holds. The input stalls only when output stalls
// leave fewer than two free entries in that buffer.
module http_uri_splitter (
  input  logic        clk_i,
  input  logic        rst_ni,

  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [7:0]  in_char_i,
  input  logic        starts_uri_i,

  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  part_o,
  output logic [7:0]  out_char_o,
  output logic [1:0]  scheme_kind_o,
  output logic [15:0] port_value_o,
  output logic        query_seen_o,
  output logic        fragment_seen_o,
  output logic [1:0]  error_code_o,
  output logic        last_o
);
  import hus_pkg::*;

  localparam int unsigned BufDepth = 4;

  // character after the scheme prefix
  function automatic body_t body_char(input logic [7:0] c, input phase_e ph,
                                      input scheme_e sch, input logic [15:0] port,
                                      input logic q, input logic f);
    body_t       b;
    logic [19:0] acc;
    part_e       p;
    logic [7:0]  oc;
    err_e        e;
    logic        l;
    b.phase = ph;
    b.port  = port;
    b.query = q;
    b.frag  = f;
    b.emit  = 1'b0;
    p  = PART_END;
    oc = c;
    e  = ERR_NONE;
    l  = 1'b0;
    acc = ({4'b0, port} << 3) + ({4'b0, port} << 1) + {12'b0, c - CH_ZERO};
    if (c == CH_NUL || is_blank(c)) begin
      b.phase = PH_DONE;
      b.emit  = 1'b1;
      oc      = CH_NUL;
      l       = 1'b1;
    end else if (ph == PH_HOST || ph == PH_PORT) begin
      if (c == CH_SLASH) begin
        b.phase = PH_PATH;
        b.emit  = 1'b1;
        p       = PART_PATH;
      end else if (c == CH_QMARK) begin
        b.phase = PH_QUERY;
        b.query = 1'b1;
      end else if (c == CH_HASH) begin
        b.phase = PH_FRAG;
        b.frag  = 1'b1;
      end else if (ph == PH_HOST) begin
        if (c == CH_COLON) begin
          b.phase = PH_PORT;
          b.port  = '0;
        end else if (is_alnum(c) || c == CH_DOT || c == CH_DASH) begin
          b.emit = 1'b1;
          p      = PART_HOST;
          oc     = to_lower(c);
        end else begin
          b.phase = PH_DONE;
          b.emit  = 1'b1;
          oc      = CH_NUL;
          e       = ERR_HOST;
          l       = 1'b1;
        end
      end else if (is_digit(c)) begin
        b.port = (acc > {4'b0, PORT_MAX}) ? PORT_MAX : acc[15:0];
        b.emit = 1'b1;
        p      = PART_PORT;
      end else begin
        b.phase = PH_DONE;
        b.emit  = 1'b1;
        oc      = CH_NUL;
        e       = ERR_PORT;
        l       = 1'b1;
      end
    end else if (ph == PH_PATH) begin
      if (c == CH_QMARK) begin
        b.phase = PH_QUERY;
        b.query = 1'b1;
      end else if (c == CH_HASH) begin
        b.phase = PH_FRAG;
        b.frag  = 1'b1;
      end else begin
        b.emit = 1'b1;
        p      = PART_PATH;
      end
    end else if (ph == PH_QUERY) begin
      if (c == CH_HASH) begin
        b.phase = PH_FRAG;
        b.frag  = 1'b1;
      end else begin
        b.emit = 1'b1;
        p      = PART_QUERY;
      end
    end else if (ph == PH_FRAG) begin
      b.emit = 1'b1;
      p      = PART_FRAG;
    end
    b.res.part   = p;
    b.res.ch     = oc;
    b.res.scheme = sch;
    b.res.port   = b.port;
    b.res.query  = b.query;
    b.res.frag   = b.frag;
    b.res.err    = e;
    b.res.last   = l;
    return b;
  endfunction

  // input register
  logic        s1_valid_q, s1_valid_d;
  logic [7:0]  s1_char_q;
  logic        s1_start_q;

  // parse state
  phase_e      phase_q, phase_d;
  logic [3:0]  prefix_pos_q, prefix_pos_d;
  scheme_e     scheme_q, scheme_d;
  logic [15:0] port_acc_q, port_acc_d;
  logic        query_q, query_d;
  logic        frag_q, frag_d;

  // result buffer
  result_t     buf_q [BufDepth];
  logic [1:0]  wr_ptr_q, wr_ptr_d;
  logic [1:0]  rd_ptr_q, rd_ptr_d;
  logic [2:0]  cnt_q, cnt_d;

  logic        proc;
  logic        pop;
  logic        push0, push1;
  result_t     r0, r1;
  logic [1:0]  n_push;

  phase_e      ph;
  logic [3:0]  pos;
  scheme_e     sch;
  logic [15:0] port;
  logic        qf, ff;
  logic [7:0]  c, lc;
  body_t       bd;
  result_t     fail_r;
  logic        pfx_ok;

  assign proc       = s1_valid_q && (cnt_q <= 3'd2);
  assign in_stall_o = s1_valid_q && !proc;
  assign out_valid_o = (cnt_q != 3'd0);
  assign pop        = out_valid_o && !out_stall_i;

  always_comb begin
    // a new uri drops whatever was being parsed
    ph   = s1_start_q ? PH_START : phase_q;
    pos  = s1_start_q ? PP_NONE  : prefix_pos_q;
    sch  = s1_start_q ? SCH_NONE : scheme_q;
    port = s1_start_q ? 16'd0    : port_acc_q;
    qf   = s1_start_q ? 1'b0     : query_q;
    ff   = s1_start_q ? 1'b0     : frag_q;
    c    = s1_char_q;
    lc   = to_lower(s1_char_q);

    bd = body_char(c, (ph == PH_SLASH) ? PH_PATH : ph, sch, port, qf, ff);

    fail_r.part   = PART_END;
    fail_r.ch     = CH_NUL;
    fail_r.scheme = sch;
    fail_r.port   = port;
    fail_r.query  = qf;
    fail_r.frag   = ff;
    fail_r.err    = ERR_SCHEME;
    fail_r.last   = 1'b1;

    phase_d      = ph;
    prefix_pos_d = pos;
    scheme_d     = sch;
    port_acc_d   = port;
    query_d      = qf;
    frag_d       = ff;
    push0        = 1'b0;
    push1        = 1'b0;
    r0           = fail_r;
    r1           = bd.res;
    pfx_ok       = 1'b0;

    unique case (ph)
      PH_START: begin
        if (c == CH_SLASH) begin
          phase_d = PH_SLASH;
        end else if (lc == CH_LC_H) begin
          phase_d      = PH_PREFIX;
          prefix_pos_d = PP_H;
        end else begin
          phase_d = PH_DONE;
          push0   = 1'b1;
        end
      end
      PH_SLASH: begin
        if (c == CH_SLASH) begin
          phase_d = PH_HOST;
        end else begin
          // lone slash: emit it as path, then parse this character as path
          r0.part  = PART_PATH;
          r0.ch    = CH_SLASH;
          r0.err   = ERR_NONE;
          r0.last  = 1'b0;
          push0    = 1'b1;
          push1    = bd.emit;
          phase_d  = bd.phase;
          port_acc_d = bd.port;
          query_d  = bd.query;
          frag_d   = bd.frag;
        end
      end
      PH_PREFIX: begin
        unique case (pos)
          PP_H: begin
            if (lc == CH_LC_T) begin
              pfx_ok = 1'b1;
              prefix_pos_d = PP_HT;
            end
          end
          PP_HT: begin
            if (lc == CH_LC_T) begin
              pfx_ok = 1'b1;
              prefix_pos_d = PP_HTT;
            end
          end
          PP_HTT: begin
            if (lc == CH_LC_P) begin
              pfx_ok = 1'b1;
              prefix_pos_d = PP_HTTP;
            end
          end
          PP_HTTP: begin
            if (c == CH_COLON) begin
              pfx_ok = 1'b1;
              prefix_pos_d = PP_COLON;
            end else if (lc == CH_LC_S) begin
              pfx_ok = 1'b1;
              prefix_pos_d = PP_S;
            end
          end
          PP_COLON: begin
            if (c == CH_SLASH) begin
              pfx_ok = 1'b1;
              prefix_pos_d = PP_SLASH1;
            end
          end
          PP_SLASH1: begin
            if (c == CH_SLASH) begin
              pfx_ok   = 1'b1;
              scheme_d = SCH_HTTP;
              phase_d  = PH_HOST;
            end
          end
          PP_S: begin
            if (c == CH_COLON) begin
              pfx_ok = 1'b1;
              prefix_pos_d = PP_S_COLON;
            end
          end
          PP_S_COLON: begin
            if (c == CH_SLASH) begin
              pfx_ok = 1'b1;
              prefix_pos_d = PP_S_SLASH1;
            end
          end
          PP_S_SLASH1: begin
            if (c == CH_SLASH) begin
              pfx_ok   = 1'b1;
              scheme_d = SCH_HTTPS;
              phase_d  = PH_HOST;
            end
          end
          default: pfx_ok = 1'b0;
        endcase
        if (!pfx_ok) begin
          phase_d = PH_DONE;
          push0   = 1'b1;
        end
      end
      PH_HOST, PH_PORT, PH_PATH, PH_QUERY, PH_FRAG: begin
        r0         = bd.res;
        push0      = bd.emit;
        phase_d    = bd.phase;
        port_acc_d = bd.port;
        query_d    = bd.query;
        frag_d     = bd.frag;
      end
      default: begin
        // finished uri: ignore characters until the next start
        phase_d = ph;
      end
    endcase
  end

  assign n_push   = {1'b0, proc && push0} + {1'b0, proc && push1};
  assign wr_ptr_d = wr_ptr_q + n_push;
  assign rd_ptr_d = rd_ptr_q + {1'b0, pop};
  assign cnt_d    = cnt_q + {1'b0, n_push} - {2'b0, pop};

  always_comb begin
    s1_valid_d = s1_valid_q;
    if (in_valid_i && !in_stall_o) begin
      s1_valid_d = 1'b1;
    end else if (proc) begin
      s1_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q   <= 1'b0;
      phase_q      <= PH_START;
      prefix_pos_q <= PP_NONE;
      scheme_q     <= SCH_NONE;
      port_acc_q   <= '0;
      query_q      <= 1'b0;
      frag_q       <= 1'b0;
      wr_ptr_q     <= '0;
      rd_ptr_q     <= '0;
      cnt_q        <= '0;
    end else begin
      s1_valid_q <= s1_valid_d;
      if (proc) begin
        phase_q      <= phase_d;
        prefix_pos_q <= prefix_pos_d;
        scheme_q     <= scheme_d;
        port_acc_q   <= port_acc_d;
        query_q      <= query_d;
        frag_q       <= frag_d;
      end
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      s1_char_q  <= in_char_i;
      s1_start_q <= starts_uri_i;
    end
    if (proc && push0) begin
      buf_q[wr_ptr_q] <= r0;
    end
    if (proc && push1) begin
      buf_q[wr_ptr_q + 2'd1] <= r1;
    end
  end

  result_t head;
  assign head = buf_q[rd_ptr_q];

  assign part_o          = head.part;
  assign out_char_o      = head.ch;
  assign scheme_kind_o   = head.scheme;
  assign port_value_o    = head.port;
  assign query_seen_o    = head.query;
  assign fragment_seen_o = head.frag;
  assign error_code_o    = head.err;
  assign last_o          = head.last;

  `HUS_ASSERT(a_buf_bound, clk_i, !rst_ni || cnt_q <= 3'd4, "result buffer overfilled")
  `HUS_ASSERT_RST(a_pair_is_slash, clk_i, rst_ni,
    (proc && push1) |-> (r0.part == PART_PATH && !r0.last),
    "second result without a leading path slash")
  `HUS_ASSERT_RST(a_last_ends, clk_i, rst_ni,
    (proc && ((push0 && r0.last) || (push1 && r1.last))) |=> (phase_q == PH_DONE),
    "closing result did not finish the parse")
  `HUS_ASSERT_RST(a_port_phase, clk_i, rst_ni,
    (port_acc_q != 16'd0) |-> (phase_q == PH_PORT || phase_q == PH_PATH ||
      phase_q == PH_QUERY || phase_q == PH_FRAG || phase_q == PH_DONE),
    "port value outside the port part")

endmodule
